// File: rtl/core/vtpl_pkg.sv
// Shared types and constants for the volume table path lookup block.
`timescale 1ns / 1ps
package vtpl_pkg;
    localparam int TableEntries = 64;
    localparam int IdxW = $clog2(TableEntries);
    localparam int CntW = $clog2(TableEntries + 1);
    localparam logic [CntW-1:0] FullCount = CntW'(TableEntries);
    localparam logic [IdxW-1:0] LastPos = IdxW'(TableEntries - 1);

    localparam logic [1:0] ET_RAW = 2'd0;
    localparam logic [1:0] ET_MBR = 2'd1;
    localparam logic [1:0] ET_GPT = 2'd2;
    localparam logic [1:0] ET_NET = 2'd3;

    localparam logic [2:0] DS_INVALID  = 3'd0;
    localparam logic [2:0] DS_NET      = 3'd1;
    localparam logic [2:0] DS_ORIGIN   = 3'd2;
    localparam logic [2:0] DS_HD       = 3'd3;
    localparam logic [2:0] DS_CD       = 3'd4;
    localparam logic [2:0] DS_GUID     = 3'd5;
    localparam logic [2:0] DS_ANY      = 3'd6;
    localparam logic [2:0] DS_RESERVED = 3'd7;

    localparam logic [2:0] PS_INVALID = 3'd0;
    localparam logic [2:0] PS_ORIGIN  = 3'd1;
    localparam logic [2:0] PS_RAW     = 3'd2;
    localparam logic [2:0] PS_INDEX   = 3'd3;
    localparam logic [2:0] PS_GUID    = 3'd4;

    localparam logic [2:0] ST_MISS   = 3'd0;
    localparam logic [2:0] ST_HIT    = 3'd1;
    localparam logic [2:0] ST_ORIGIN = 3'd2;
    localparam logic [2:0] ST_ADDED  = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;
    localparam logic [2:0] ST_NETREF = 3'd5;

    localparam logic [0:0] CFG_ORIGIN_NUM  = 1'd0;
    localparam logic [0:0] CFG_ORIGIN_KIND = 1'd1;

    typedef struct packed {
        logic [1:0]   vol_type;
        logic         media_kind;
        logic [7:0]   disk_number;
        logic [7:0]   partition_number;
        logic [127:0] dsk_guid;
        logic [127:0] part_guid;
    } t_entry;

    typedef struct packed {
        logic         by_index;
        logic         by_guid;
        logic         by_pidx;
        logic         raw;
        logic [7:0]   want_disk;
        logic         want_kind;
        logic [7:0]   want_part;
        logic [127:0] dsk_guid;
        logic [127:0] part_guid;
    } t_query;

    typedef struct packed {
        logic            func;
        logic [1:0]      vol_type;
        logic            media_kind;
        logic [2:0]      disk_selector;
        logic [2:0]      partition_selector;
        logic [7:0]      disk_number;
        logic [7:0]      partition_number;
        logic [63:0]     disk_guid_high;
        logic [63:0]     disk_guid_low;
        logic [63:0]     part_guid_high;
        logic [63:0]     part_guid_low;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] entry_index;
    } t_out;
endpackage

// File: rtl/core/vtpl_if.sv
// Valid/ready channel interface with payload.
`timescale 1ns / 1ps
interface vtpl_in_if;
    logic          valid;
    logic          ready;
    vtpl_pkg::t_in payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface vtpl_out_if;
    logic           valid;
    logic           ready;
    vtpl_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/vtpl_cell.sv
// One table cell: holds an entry, matches the passing query, shifts entries on add and on scan rotation.
`timescale 1ns / 1ps
module vtpl_cell (
    input  logic                   i_clk,
    input  logic                   i_load,
    input  vtpl_pkg::t_entry       i_entry,
    input  vtpl_pkg::t_query       i_query,
    output vtpl_pkg::t_entry       o_entry,
    output logic                   o_match
);
    vtpl_pkg::t_entry r_entry;
    logic             n_match;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_entry;
        end
    end

    always_comb begin
        n_match = (r_entry.vol_type != vtpl_pkg::ET_NET);
        if (i_query.by_index) begin
            if (r_entry.disk_number != i_query.want_disk ||
                r_entry.media_kind != i_query.want_kind) begin
                n_match = 1'b0;
            end
        end else if (i_query.by_guid) begin
            if (r_entry.dsk_guid != i_query.dsk_guid) begin
                n_match = 1'b0;
            end
        end
        if (i_query.raw) begin
            if (r_entry.vol_type != vtpl_pkg::ET_RAW) begin
                n_match = 1'b0;
            end
        end else begin
            if (r_entry.vol_type == vtpl_pkg::ET_RAW) begin
                n_match = 1'b0;
            end
            if (i_query.by_pidx) begin
                if (r_entry.partition_number != i_query.want_part) begin
                    n_match = 1'b0;
                end
            end else if (r_entry.part_guid != i_query.part_guid) begin
                n_match = 1'b0;
            end
        end
    end

    assign o_entry = r_entry;
    assign o_match = n_match;
endmodule

// File: rtl/core/volume_table_path_lookup_top.sv
// Top level of the volume table: cell chain, scan control and output register.
// Add, refused add, network, origin and invalid lookups: result registered, valid in the cycle after acceptance.
// Scanned lookup: the chain rotates one full turn in the scan state, then the result is presented.
// One transaction at a time: no new input is accepted until the result has been taken.
// Reset (synchronous, active low): count, network flags, origin registers cleared.
// Cell contents are not cleared and are only read below the entry count.
`timescale 1ns / 1ps
module volume_table_path_lookup_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    vtpl_in_if.sink     in_ch,
    vtpl_out_if.source  out_ch
);
    localparam int N = vtpl_pkg::TableEntries;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]                 r_state;
    logic [vtpl_pkg::CntW-1:0]  r_count;
    logic [vtpl_pkg::IdxW-1:0]  r_pos;
    logic                       r_net;
    logic [vtpl_pkg::IdxW-1:0]  r_net_idx;
    logic [7:0]                 r_org_num;
    logic                       r_org_kind;
    vtpl_pkg::t_query           r_query;
    vtpl_pkg::t_query           n_query;
    vtpl_pkg::t_out             r_out;
    vtpl_pkg::t_out             n_out;
    logic                       n_scan;
    vtpl_pkg::t_entry           n_new;
    vtpl_pkg::t_entry           w_ent [N];
    logic                       w_match [N];
    logic                       r_found;
    logic                       w_load;
    logic                       w_rot;
    logic                       w_full;
    logic                       w_netref;
    logic [vtpl_pkg::CntW-1:0]  w_sum;
    logic                       w_valid;
    vtpl_pkg::t_in              w_in;
    logic                       w_acc;

    assign w_in  = in_ch.payload;
    assign w_acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (r_state == S_IDLE);
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.payload = r_out;

    // Add inserts at cell 0 and shifts; a scanned lookup rotates the whole ring one full turn.
    assign w_full   = (r_count >= vtpl_pkg::FullCount);
    assign w_netref = (w_in.vol_type == vtpl_pkg::ET_NET) && r_net;
    assign w_load   = w_acc && !w_in.func && !w_full && !w_netref;
    assign w_rot    = (r_state == S_SCAN);
    // Entry index at the last cell after r_pos rotations; valid once it reaches the oldest.
    assign w_sum    = {1'b0, r_pos} + r_count;
    assign w_valid  = (w_sum >= vtpl_pkg::FullCount);

    always_comb begin
        n_new = '0;
        n_new.vol_type = w_in.vol_type;
        if (w_in.vol_type != vtpl_pkg::ET_NET) begin
            n_new.media_kind = w_in.media_kind;
            n_new.disk_number = w_in.disk_number;
            if (w_in.vol_type != vtpl_pkg::ET_RAW) begin
                n_new.partition_number = w_in.partition_number;
            end
        end
        if (w_in.vol_type == vtpl_pkg::ET_GPT) begin
            n_new.dsk_guid = {w_in.disk_guid_high, w_in.disk_guid_low};
            n_new.part_guid = {w_in.part_guid_high, w_in.part_guid_low};
        end
    end

    always_comb begin
        n_query = '0;
        n_query.dsk_guid = {w_in.disk_guid_high, w_in.disk_guid_low};
        n_query.part_guid = {w_in.part_guid_high, w_in.part_guid_low};
        n_query.want_part = w_in.partition_number;
        case (w_in.disk_selector)
            vtpl_pkg::DS_ORIGIN: begin
                n_query.by_index = 1'b1;
                n_query.want_disk = r_org_num;
                n_query.want_kind = r_org_kind;
            end
            vtpl_pkg::DS_HD: begin
                n_query.by_index = 1'b1;
                n_query.want_disk = w_in.disk_number;
            end
            vtpl_pkg::DS_CD: begin
                n_query.by_index = 1'b1;
                n_query.want_disk = w_in.disk_number;
                n_query.want_kind = 1'b1;
            end
            vtpl_pkg::DS_GUID: n_query.by_guid = 1'b1;
            default: ;
        endcase
        n_query.by_pidx = (w_in.partition_selector == vtpl_pkg::PS_INDEX);
        n_query.raw = (w_in.partition_selector == vtpl_pkg::PS_RAW);
    end

    always_comb begin
        n_out = '0;
        n_out.status = vtpl_pkg::ST_MISS;
        n_scan = 1'b0;
        if (!w_in.func) begin
            if (w_full) begin
                n_out.status = vtpl_pkg::ST_FULL;
            end else if (w_netref) begin
                n_out.status = vtpl_pkg::ST_NETREF;
            end else begin
                n_out.status = vtpl_pkg::ST_ADDED;
                n_out.entry_index = r_count[vtpl_pkg::IdxW-1:0];
            end
        end else if (w_in.disk_selector == vtpl_pkg::DS_INVALID ||
                     w_in.disk_selector == vtpl_pkg::DS_RESERVED ||
                     w_in.partition_selector == vtpl_pkg::PS_INVALID ||
                     w_in.partition_selector > vtpl_pkg::PS_GUID) begin
            n_out.status = vtpl_pkg::ST_MISS;
        end else if (w_in.disk_selector == vtpl_pkg::DS_NET) begin
            if (r_net) begin
                n_out.status = vtpl_pkg::ST_HIT;
                n_out.entry_index = r_net_idx;
            end
        end else if (w_in.disk_selector == vtpl_pkg::DS_ORIGIN &&
                     (w_in.partition_selector == vtpl_pkg::PS_ORIGIN ||
                      w_in.partition_selector == vtpl_pkg::PS_RAW)) begin
            n_out.status = vtpl_pkg::ST_ORIGIN;
        end else begin
            n_scan = 1'b1;
        end
    end

    // Scan order: cell N-1 holds the oldest entry once rotated into alignment.
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            vtpl_pkg::t_entry w_src;
            if (g == 0) begin : g_head
                assign w_src = w_rot ? w_ent[N-1] : n_new;
            end else begin : g_body
                assign w_src = w_ent[g-1];
            end
            vtpl_cell u_cell (
                .i_clk   (i_clk),
                .i_load  (w_load || w_rot),
                .i_entry (w_src),
                .i_query (r_query),
                .o_entry (w_ent[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_num <= '0;
            r_org_kind <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vtpl_pkg::CFG_ORIGIN_NUM:  r_org_num <= i_cfg_data;
                vtpl_pkg::CFG_ORIGIN_KIND: r_org_kind <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_net <= 1'b0;
            r_net_idx <= '0;
            r_pos <= '0;
            r_found <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_query <= n_query;
                        r_out <= n_out;
                        r_pos <= '0;
                        r_found <= 1'b0;
                        r_state <= n_scan ? S_SCAN : S_OUT;
                    end
                    if (w_load) begin
                        r_count <= r_count + 1'b1;
                        if (w_in.vol_type == vtpl_pkg::ET_NET) begin
                            r_net <= 1'b1;
                            r_net_idx <= r_count[vtpl_pkg::IdxW-1:0];
                        end
                    end
                end
                S_SCAN: begin
                    // Keep the first hit; finish the full turn to restore the ring.
                    if (w_valid && w_match[N-1] && !r_found) begin
                        r_found <= 1'b1;
                        r_out <= '{status: vtpl_pkg::ST_HIT,
                                   entry_index: w_sum[vtpl_pkg::IdxW-1:0]};
                    end
                    if (r_pos == vtpl_pkg::LastPos) begin
                        r_state <= S_OUT;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_ch.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/core/vtpl_checker.sv
// Port-level checker for the volume table, bound to the top level.
`timescale 1ns / 1ps
module vtpl_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [2:0] out_status
);
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_out_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready did not drop");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_status <= 3'd5) else $error("bad status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_status))
        else $error("result dropped");
endmodule

bind volume_table_path_lookup_top vtpl_checker u_vtpl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.payload.status)
);
